### src/cbf_pkg.sv
// cbf_pkg: request codes, status codes and field widths for the circular byte fifo
// used by circular_byte_fifo_core and its port checker; depends on nothing
package cbf_pkg;

	// request kinds carried on the input tuser
	typedef enum logic [1:0] {
		REQ_WRITE  = 2'd0,
		REQ_READ   = 2'd1,
		REQ_REMOVE = 2'd2,
		REQ_STATUS = 2'd3
	} req_t;

	// result status carried on the output tuser
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_OVER  = 2'd2,
		ST_RSVD  = 2'd3
	} status_t;

	// fixed field widths
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned LEN_W   = 7;
	localparam int unsigned LEVEL_W = 11;
	localparam int unsigned COUNT_W = 32;

	// output tdata layout, lowest bit first
	localparam int unsigned OFS_BYTE   = 0;
	localparam int unsigned OFS_FILL   = OFS_BYTE + BYTE_W;
	localparam int unsigned OFS_FREE   = OFS_FILL + LEVEL_W;
	localparam int unsigned OFS_CONTIG = OFS_FREE + LEVEL_W;
	localparam int unsigned OFS_COUNT  = OFS_CONTIG + LEVEL_W;
	localparam int unsigned OUT_BITS   = OFS_COUNT + COUNT_W;
	localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	// input tdata width: wr_byte, block_len, clear_counter
	localparam int unsigned IN_DATA_W = 16;

endpackage

### src/cbf_ram.sv
// cbf_ram: generic simple dual-port ram, one write and one registered read port
// depends on nothing
module cbf_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### src/circular_byte_fifo_core.sv
// circular_byte_fifo_core: byte ring buffer with write, block read, block remove and status
// depends on cbf_pkg and cbf_ram
//
// channel  dir  tdata (low bit first)                           tuser       tlast
// s_axis   in   wr_byte[7:0] block_len[14:8] clear_counter[15]  req_type    -
// m_axis   out  rd_byte fill_level free_space contiguous_len    status      last
//               byte_count, zero padded to 80 bits
//
// a write, remove, status or failed or empty read: accept, then result stage, then output register
// a read of N bytes: accept, then N ram reads through the result stage, then the last byte drains
// the next request is taken once the last result of a request sits in the output register
// arst_n clears pointers, fill level and byte counter; the ram itself is not cleared
// a stalled output holds its result and the read sequencer waits with it
module circular_byte_fifo_core #(
	parameter int unsigned DEPTH     = 1024,
	parameter int unsigned MAX_BLOCK = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [cbf_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // wr_byte, block_len, clear_counter
	input  logic [1:0]                        s_axis_tuser,  // req_type
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [cbf_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // rd_byte, fill_level, free_space,
	                                                         // contiguous_len, byte_count
	output logic [1:0]                        m_axis_tuser,  // status
	output logic                              m_axis_tlast
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned CMP_W = (CNT_W > cbf_pkg::LEN_W) ? CNT_W : cbf_pkg::LEN_W;
	localparam int unsigned SUM_W = ((PTR_W > cbf_pkg::LEN_W) ? PTR_W : cbf_pkg::LEN_W) + 1;
	localparam int unsigned CS_W  = CNT_W + 1;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

	state_t                        state_q;
	logic [PTR_W-1:0]              rp_q;
	logic [PTR_W-1:0]              wp_q;
	logic [CNT_W-1:0]              fill_q;
	logic [cbf_pkg::COUNT_W-1:0]   wc_q;
	logic [PTR_W-1:0]              rd_addr_q;
	logic [cbf_pkg::LEN_W-1:0]     remain_q;

	// result stage
	logic                          valid_s1;
	logic                          is_byte_s1;
	logic                          last_s1;
	cbf_pkg::status_t              status_s1;
	logic [cbf_pkg::COUNT_W-1:0]   count_s1;

	// request fields
	cbf_pkg::req_t                 req;
	logic [cbf_pkg::BYTE_W-1:0]    wr_byte;
	logic [cbf_pkg::LEN_W-1:0]     block_len;
	logic                          clear_counter;

	logic                          accept;
	logic                          out_load;
	logic                          issue;
	logic                          full;
	logic                          under;
	logic                          read_go;
	cbf_pkg::status_t              acc_status;
	logic [cbf_pkg::COUNT_W-1:0]   acc_count;
	logic [cbf_pkg::LEN_W-1:0]     len_sat;
	logic [CNT_W-1:0]              fill_after;
	logic [SUM_W-1:0]              rp_sum;
	logic [PTR_W-1:0]              rp_next;
	logic [PTR_W-1:0]              wp_inc;
	logic [PTR_W-1:0]              rd_addr_inc;
	logic [CNT_W-1:0]              contig;
	logic [CNT_W-1:0]              free_now;
	logic [cbf_pkg::BYTE_W-1:0]    ram_rdata;
	logic                          ram_we;

	assign req           = cbf_pkg::req_t'(s_axis_tuser);
	assign wr_byte       = s_axis_tdata[7:0];
	assign block_len     = s_axis_tdata[14:8];
	assign clear_counter = s_axis_tdata[15];

	// handshakes
	assign s_axis_tready = (state_q == ST_IDLE) && !valid_s1;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_load      = valid_s1 && (!m_axis_tvalid || m_axis_tready);
	assign issue         = (state_q == ST_READ) && (!valid_s1 || out_load);

	// block length checks
	assign len_sat = (block_len > cbf_pkg::LEN_W'(MAX_BLOCK)) ?
		cbf_pkg::LEN_W'(MAX_BLOCK) : block_len;
	assign under      = CMP_W'(len_sat) > CMP_W'(fill_q);
	assign full       = fill_q == CNT_W'(DEPTH);
	assign fill_after = fill_q - CNT_W'(len_sat);

	// streaming read check, and status and count of the single result of any other request
	assign read_go    = (req == cbf_pkg::REQ_READ) && !under && (len_sat != '0);
	assign acc_status = ((req == cbf_pkg::REQ_WRITE) && full) ? cbf_pkg::ST_OVER :
		((req inside {cbf_pkg::REQ_READ, cbf_pkg::REQ_REMOVE}) && under) ?
		cbf_pkg::ST_UNDER : cbf_pkg::ST_OK;
	assign acc_count  = ((req == cbf_pkg::REQ_WRITE) && !full) ? wc_q + 1'b1 : wc_q;

	// pointer arithmetic with wrap
	assign rp_sum  = SUM_W'(rp_q) + SUM_W'(len_sat);
	assign rp_next = (rp_sum >= SUM_W'(DEPTH)) ?
		PTR_W'(rp_sum - SUM_W'(DEPTH)) : PTR_W'(rp_sum);
	assign wp_inc      = (wp_q == PTR_W'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
	assign rd_addr_inc = (rd_addr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_addr_q + 1'b1;

	// reporting values from the current state
	assign contig = ((CS_W'(rp_q) + CS_W'(fill_q)) > CS_W'(DEPTH)) ?
		CNT_W'(DEPTH) - CNT_W'(rp_q) : fill_q;
	assign free_now = CNT_W'(DEPTH) - fill_q;

	assign ram_we = accept && (req == cbf_pkg::REQ_WRITE) && !full;

	cbf_ram #(
		.WIDTH(cbf_pkg::BYTE_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wp_q),
		.wdata(wr_byte),
		.re   (issue),
		.raddr(rd_addr_q),
		.rdata(ram_rdata)
	);

	// request handling, read sequencer, result stage and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			rp_q          <= '0;
			wp_q          <= '0;
			fill_q        <= '0;
			wc_q          <= '0;
			rd_addr_q     <= '0;
			remain_q      <= '0;
			valid_s1      <= 1'b0;
			is_byte_s1    <= 1'b0;
			last_s1       <= 1'b0;
			status_s1     <= cbf_pkg::ST_OK;
			count_s1      <= '0;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata  <= '0;
			m_axis_tuser  <= '0;
			m_axis_tlast  <= 1'b0;
		end else begin
			// output register
			if (out_load) begin
				m_axis_tvalid <= 1'b1;
				m_axis_tdata  <= cbf_pkg::OUT_DATA_W'({
					count_s1,
					cbf_pkg::LEVEL_W'(contig),
					cbf_pkg::LEVEL_W'(free_now),
					cbf_pkg::LEVEL_W'(fill_q),
					is_byte_s1 ? ram_rdata : 8'd0});
				m_axis_tuser  <= status_s1;
				m_axis_tlast  <= last_s1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end

			if (issue) begin
				// read sequencer issues one ram read per cycle while the result stage can drain
				valid_s1   <= 1'b1;
				is_byte_s1 <= 1'b1;
				last_s1    <= remain_q == 7'd1;
				status_s1  <= cbf_pkg::ST_OK;
				count_s1   <= wc_q;
				rd_addr_q  <= rd_addr_inc;
				remain_q   <= remain_q - 1'b1;
				if (remain_q == 7'd1) begin
					state_q <= ST_IDLE;
				end
			end else if (accept) begin
				// new request; a streaming read fills the result stage later
				valid_s1   <= !read_go;
				is_byte_s1 <= 1'b0;
				last_s1    <= 1'b1;
				status_s1  <= acc_status;
				count_s1   <= acc_count;
				case (req)
					cbf_pkg::REQ_WRITE: begin
						if (!full) begin
							wp_q   <= wp_inc;
							fill_q <= fill_q + 1'b1;
							wc_q   <= wc_q + 1'b1;
						end
					end
					cbf_pkg::REQ_STATUS: begin
						if (clear_counter) begin
							wc_q <= '0;
						end
					end
					cbf_pkg::REQ_READ, cbf_pkg::REQ_REMOVE: begin
						if (!under && (len_sat != '0)) begin
							fill_q <= fill_after;
							if (fill_after == '0) begin
								rp_q <= '0;
								wp_q <= '0;
							end else begin
								rp_q <= rp_next;
							end
							if (req == cbf_pkg::REQ_READ) begin
								// bytes come from the old read pointer
								state_q   <= ST_READ;
								rd_addr_q <= rp_q;
								remain_q  <= len_sat;
							end
						end
					end
					default: ;
				endcase
			end else if (out_load) begin
				// result stage drains into the output register
				valid_s1 <= 1'b0;
			end
		end
	end

endmodule

### src/cbf_checker.sv
// cbf_checker: port-level checks on circular_byte_fifo_core, bound into every instance of it
// depends on cbf_pkg; the bind below names circular_byte_fifo_core
module cbf_checker #(
	parameter int unsigned DEPTH = 1024
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [cbf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic [1:0]                     m_axis_tuser,
	input logic                           m_axis_tlast
);

	localparam logic [cbf_pkg::LEVEL_W-1:0] DEPTH_LVL = cbf_pkg::LEVEL_W'(DEPTH);

	logic [cbf_pkg::LEVEL_W-1:0] fill;
	logic [cbf_pkg::LEVEL_W-1:0] free;
	logic [cbf_pkg::LEVEL_W-1:0] contig;

	assign fill   = m_axis_tdata[cbf_pkg::OFS_FILL +: cbf_pkg::LEVEL_W];
	assign free   = m_axis_tdata[cbf_pkg::OFS_FREE +: cbf_pkg::LEVEL_W];
	assign contig = m_axis_tdata[cbf_pkg::OFS_CONTIG +: cbf_pkg::LEVEL_W];

	// a stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	// fill and free always add up to the depth
	a_fill_free: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (cbf_pkg::LEVEL_W'(fill + free) == DEPTH_LVL))
		else $error("fill_level and free_space disagree");

	// contiguous run never exceeds the fill level
	a_contig: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (contig <= fill))
		else $error("contiguous_len above fill_level");

	// an error result is always the only result of its request
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != cbf_pkg::ST_OK) |-> m_axis_tlast)
		else $error("error result not marked last");

	// no new request is taken while a multi-byte read is still streaming
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !(s_axis_tvalid && s_axis_tready))
		else $error("request accepted in the middle of a read block");

endmodule

bind circular_byte_fifo_core cbf_checker #(
	.DEPTH(DEPTH)
) u_cbf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser),
	.m_axis_tlast (m_axis_tlast)
);

### bench/tb_circular_byte_fifo_core.sv
`timescale 1ns / 1ps
// tb_circular_byte_fifo_core: self-checking bench for the circular byte fifo core
// drives write, read, remove and status requests, checks each result against its own predictor
// depends on cbf_pkg and circular_byte_fifo_core

module tb_circular_byte_fifo_core;

	localparam int unsigned FIFO_DEPTH = 1024;
	localparam int unsigned BLOCK_MAX  = 64;

	// one result as seen on the output channel
	typedef struct packed {
		logic [cbf_pkg::BYTE_W-1:0]  rd_byte;
		logic                        last;
		cbf_pkg::status_t            status;
		logic [cbf_pkg::LEVEL_W-1:0] fill_level;
		logic [cbf_pkg::LEVEL_W-1:0] free_space;
		logic [cbf_pkg::LEVEL_W-1:0] contiguous_len;
		logic [cbf_pkg::COUNT_W-1:0] byte_count;
	} fifo_result_t;

	// receiver ready patterns
	typedef enum int unsigned {
		SINK_ALWAYS  = 0,
		SINK_MOSTLY  = 1,
		SINK_PATTERN = 2,
		SINK_RARELY  = 3
	} sink_mode_t;

	// ring buffer predictor and queue of expected results
	class fifo_scoreboard;
		logic [cbf_pkg::BYTE_W-1:0]  ring [FIFO_DEPTH];
		int unsigned                 rd_ptr;
		int unsigned                 wr_ptr;
		int unsigned                 fill;
		logic [cbf_pkg::COUNT_W-1:0] written;
		fifo_result_t                pending [$];
		int unsigned                 errors;

		function new();
			rd_ptr  = 0;
			wr_ptr  = 0;
			fill    = 0;
			written = '0;
			errors  = 0;
		endfunction

		// reporting fields always show the state after the whole request
		function fifo_result_t make_result(logic [cbf_pkg::BYTE_W-1:0] data, logic last,
				cbf_pkg::status_t st, logic [cbf_pkg::COUNT_W-1:0] count);
			fifo_result_t r;
			r.rd_byte        = data;
			r.last           = last;
			r.status         = st;
			r.fill_level     = cbf_pkg::LEVEL_W'(fill);
			r.free_space     = cbf_pkg::LEVEL_W'(FIFO_DEPTH - fill);
			r.contiguous_len = (rd_ptr + fill > FIFO_DEPTH) ?
				cbf_pkg::LEVEL_W'(FIFO_DEPTH - rd_ptr) : cbf_pkg::LEVEL_W'(fill);
			r.byte_count     = count;
			return r;
		endfunction

		// note an accepted request and queue the results it causes
		function void note_request(cbf_pkg::req_t req, logic [cbf_pkg::BYTE_W-1:0] data,
				logic [cbf_pkg::LEN_W-1:0] len_in, logic clr);
			int unsigned                 len;
			int unsigned                 i;
			logic [cbf_pkg::BYTE_W-1:0]  taken [$];
			logic [cbf_pkg::COUNT_W-1:0] reported;
			len = (len_in > BLOCK_MAX) ? BLOCK_MAX : len_in;
			case (req)
				cbf_pkg::REQ_WRITE: begin
					if (fill >= FIFO_DEPTH) begin
						pending.push_back(make_result('0, 1'b1, cbf_pkg::ST_OVER, written));
					end else begin
						ring[wr_ptr] = data;
						wr_ptr = (wr_ptr + 1) % FIFO_DEPTH;
						fill++;
						written++;
						pending.push_back(make_result('0, 1'b1, cbf_pkg::ST_OK, written));
					end
				end
				cbf_pkg::REQ_STATUS: begin
					reported = written;
					if (clr)
						written = '0;
					pending.push_back(make_result('0, 1'b1, cbf_pkg::ST_OK, reported));
				end
				default: begin
					if (len > fill) begin
						pending.push_back(make_result('0, 1'b1, cbf_pkg::ST_UNDER, written));
					end else if (len == 0) begin
						pending.push_back(make_result('0, 1'b1, cbf_pkg::ST_OK, written));
					end else begin
						for (i = 0; i < len; i++) begin
							taken.push_back(ring[rd_ptr]);
							rd_ptr = (rd_ptr + 1) % FIFO_DEPTH;
						end
						fill -= len;
						// an empty buffer puts both pointers back at the start
						if (fill == 0) begin
							rd_ptr = 0;
							wr_ptr = 0;
						end
						if (req == cbf_pkg::REQ_REMOVE) begin
							pending.push_back(make_result('0, 1'b1, cbf_pkg::ST_OK, written));
						end else begin
							for (i = 0; i < len; i++)
								pending.push_back(make_result(taken[i], i == len - 1,
									cbf_pkg::ST_OK, written));
						end
					end
				end
			endcase
		endfunction

		function void compare_field(string name, longint unsigned want, longint unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		// check one accepted result against the oldest expectation
		function void check_result(fifo_result_t got);
			fifo_result_t want;
			if (pending.size() == 0) begin
				$error("result with no request outstanding: rd_byte %0d status %0d",
					got.rd_byte, got.status);
				errors++;
				return;
			end
			want = pending.pop_front();
			compare_field("rd_byte", want.rd_byte, got.rd_byte);
			compare_field("last", want.last, got.last);
			compare_field("status", want.status, got.status);
			compare_field("fill_level", want.fill_level, got.fill_level);
			compare_field("free_space", want.free_space, got.free_space);
			compare_field("contiguous_len", want.contiguous_len, got.contiguous_len);
			compare_field("byte_count", want.byte_count, got.byte_count);
		endfunction
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           s_axis_tvalid;
	logic                           s_axis_tready;
	logic [cbf_pkg::IN_DATA_W-1:0]  s_axis_tdata;
	logic [1:0]                     s_axis_tuser;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready;
	logic [cbf_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic [1:0]                     m_axis_tuser;
	logic                           m_axis_tlast;

	fifo_scoreboard                 sb;
	fifo_result_t                   seen;
	sink_mode_t                     sink_mode;
	int unsigned                    sink_cycle;
	int unsigned                    burst_left;

	circular_byte_fifo_core #(
		.DEPTH     (FIFO_DEPTH),
		.MAX_BLOCK (BLOCK_MAX)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// 12 ns clock
	always #6 clk = ~clk;

	// sample both channels at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				seen.rd_byte        = m_axis_tdata[cbf_pkg::OFS_BYTE +: cbf_pkg::BYTE_W];
				seen.last           = m_axis_tlast;
				seen.status         = cbf_pkg::status_t'(m_axis_tuser);
				seen.fill_level     = m_axis_tdata[cbf_pkg::OFS_FILL +: cbf_pkg::LEVEL_W];
				seen.free_space     = m_axis_tdata[cbf_pkg::OFS_FREE +: cbf_pkg::LEVEL_W];
				seen.contiguous_len = m_axis_tdata[cbf_pkg::OFS_CONTIG +: cbf_pkg::LEVEL_W];
				seen.byte_count     = m_axis_tdata[cbf_pkg::OFS_COUNT +: cbf_pkg::COUNT_W];
				sb.check_result(seen);
			end
			if (s_axis_tvalid && s_axis_tready)
				sb.note_request(cbf_pkg::req_t'(s_axis_tuser), s_axis_tdata[7:0],
					s_axis_tdata[14:8], s_axis_tdata[15]);
		end
	end

	// receiver stalls, switching between randomly picked ready patterns
	always @(negedge clk) begin
		sink_cycle++;
		if (sink_cycle % 48 == 0)
			sink_mode = sink_mode_t'($urandom_range(0, 3));
		case (sink_mode)
			SINK_ALWAYS:  m_axis_tready <= 1'b1;
			SINK_MOSTLY:  m_axis_tready <= ($urandom_range(0, 3) != 0);
			SINK_PATTERN: m_axis_tready <= (sink_cycle % 3 != 0);
			default:      m_axis_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// present one request, with a random gap at the start of each burst
	task automatic send_request(cbf_pkg::req_t req, logic [7:0] data, logic [6:0] len,
			logic clr);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 5);
			burst_left = $urandom_range(1, 12);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {clr, len, data};
		s_axis_tuser  <= req;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// hold off the sender until every expected result has come back
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		do
			@(negedge clk);
		while (sb.pending.size() != 0);
	endtask

	// block length: mostly fitting, sometimes zero, oversized or longer than the fill
	function automatic logic [6:0] pick_len(int unsigned level);
		int unsigned sel;
		sel = $urandom_range(0, 19);
		case (sel)
			0: return 7'd0;
			1: return 7'($urandom_range(65, 127));
			2: return 7'd64;
			3: return (level < 64) ? 7'($urandom_range(level + 1, 64)) : 7'($urandom_range(1, 64));
			default: return 7'($urandom_range(1, (level == 0) ? 1 : ((level < 12) ? level : 12)));
		endcase
	endfunction

	// one random request, biased toward writes when the buffer runs low
	task automatic random_request();
		int unsigned roll;
		int unsigned level;
		logic [7:0]  data;
		logic [6:0]  len;
		logic        clr;
		roll  = $urandom_range(0, 99);
		level = sb.fill;
		data  = 8'($urandom);
		len   = 7'($urandom);
		clr   = ($urandom_range(0, 2) == 0);
		if (roll < ((level < 4) ? 60 : 40))
			send_request(cbf_pkg::REQ_WRITE, data, len, clr);
		else if (roll < 72)
			send_request(cbf_pkg::REQ_READ, data, pick_len(level), clr);
		else if (roll < 86)
			send_request(cbf_pkg::REQ_REMOVE, data, pick_len(level), clr);
		else
			send_request(cbf_pkg::REQ_STATUS, data, len, clr);
	endtask

	initial begin
		sb            = new();
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = cbf_pkg::REQ_WRITE;
		m_axis_tready = 1'b0;
		sink_mode     = SINK_ALWAYS;
		sink_cycle    = 0;
		burst_left    = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty buffer, zero and oversized blocks, byte extremes, counter clear
		send_request(cbf_pkg::REQ_STATUS, 8'h00, 7'd0, 1'b0);
		send_request(cbf_pkg::REQ_READ, 8'h00, 7'd1, 1'b0);
		send_request(cbf_pkg::REQ_READ, 8'h00, 7'd0, 1'b0);
		send_request(cbf_pkg::REQ_REMOVE, 8'h00, 7'd0, 1'b0);
		send_request(cbf_pkg::REQ_REMOVE, 8'h00, 7'd3, 1'b0);
		send_request(cbf_pkg::REQ_WRITE, 8'h00, 7'd0, 1'b0);
		send_request(cbf_pkg::REQ_WRITE, 8'hFF, 7'd127, 1'b1);
		send_request(cbf_pkg::REQ_WRITE, 8'hA5, 7'd0, 1'b0);
		send_request(cbf_pkg::REQ_WRITE, 8'h5A, 7'd0, 1'b0);
		send_request(cbf_pkg::REQ_WRITE, 8'h01, 7'd0, 1'b0);
		send_request(cbf_pkg::REQ_WRITE, 8'h80, 7'd0, 1'b0);
		send_request(cbf_pkg::REQ_READ, 8'h00, 7'd2, 1'b0);
		send_request(cbf_pkg::REQ_REMOVE, 8'h00, 7'd1, 1'b0);
		send_request(cbf_pkg::REQ_READ, 8'h00, 7'd127, 1'b0);
		send_request(cbf_pkg::REQ_REMOVE, 8'h00, 7'd64, 1'b0);
		send_request(cbf_pkg::REQ_READ, 8'h00, 7'd3, 1'b0);
		send_request(cbf_pkg::REQ_STATUS, 8'h00, 7'd0, 1'b1);
		send_request(cbf_pkg::REQ_STATUS, 8'hFF, 7'd127, 1'b0);
		send_request(cbf_pkg::REQ_WRITE, 8'h7F, 7'd0, 1'b0);
		send_request(cbf_pkg::REQ_REMOVE, 8'h00, 7'd1, 1'b0);
		send_request(cbf_pkg::REQ_STATUS, 8'h00, 7'd0, 1'b0);
		wait_drained();

		// random requests, with one full hold-off halfway through
		for (int n = 0; n < 210; n++) begin
			if (n == 105)
				wait_drained();
			random_request();
		end
		wait_drained();
		repeat (40) @(negedge clk);

		if (sb.errors == 0)
			$display("circular_byte_fifo_core regression: pass");
		else
			$display("circular_byte_fifo_core regression: fail");
		$finish;
	end

	// hang guard
	initial begin
		#10ms;
		$display("circular_byte_fifo_core regression: fail");
		$finish;
	end

endmodule
